[design/pov_pkg.sv]
// Package for the persistence-of-vision sweep controller.
// Holds the shared types, codes and reset constants. No dependencies.

package pov_pkg;

    // Default number of bitmap columns
    localparam int COLUMNS_DEF = 48;

    // Field widths
    localparam int OPCODE_W  = 2;
    localparam int ACCEL_W   = 8;
    localparam int ADDR_W    = 6;
    localparam int PIXEL_W   = 8;
    localparam int THRESH_W  = 7;
    localparam int RELOAD_W  = 8;
    localparam int TICKS_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWING_THRESHOLD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RATE_ENABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RELOAD         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIDIRECTIONAL_ENABLE = 2'd3;

    // Reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd20;
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'd178;

    // Reload acceptance window (exclusive bounds)
    localparam logic [RELOAD_W-1:0] RELOAD_MIN = 8'd40;
    localparam logic [RELOAD_W-1:0] RELOAD_MAX = 8'd225;

    // Filter rail that disables extreme detection
    localparam logic signed [ACCEL_W-1:0] FILTER_RAIL = 8'sd127;

    // Divide by 10 via reciprocal: exact for magnitudes up to 2047
    localparam logic [12:0] DIV10_MUL   = 13'd6554;
    localparam int          DIV10_SHIFT = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_WRITE  = 2'd2
    } t_opcode;

    typedef struct packed {
        t_opcode                     opcode;
        logic signed [ACCEL_W-1:0]   accel_sample;
        logic [ADDR_W-1:0]           column_address;
        logic [PIXEL_W-1:0]          column_data;
    } t_item;

    typedef struct packed {
        logic                        column_valid;
        logic [PIXEL_W-1:0]          column_pixels;
        logic                        sweep_direction;
        logic signed [ACCEL_W-1:0]   filtered_accel;
        logic [RELOAD_W-1:0]         column_reload;
    } t_result;

    typedef struct packed {
        logic [THRESH_W-1:0]         swing_threshold;
        logic                        fixed_rate_enable;
        logic [RELOAD_W-1:0]         fixed_reload;
        logic                        bidirectional_enable;
    } t_cfg;

    // Column store write request
    typedef struct packed {
        logic                        en;
        logic [ADDR_W-1:0]           addr;
        logic [PIXEL_W-1:0]          data;
    } t_store_wr;

endpackage

[design/pov_if.sv]
// Channel interfaces: item input, result output and configuration write.
// Depends on pov_pkg.

interface pov_item_if;
    import pov_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OPCODE_W-1:0]       opcode;
    logic signed [ACCEL_W-1:0] accel_sample;
    logic [ADDR_W-1:0]         column_address;
    logic [PIXEL_W-1:0]        column_data;

    modport source (output valid, opcode, accel_sample, column_address, column_data,
                    input ready);
    modport sink   (input valid, opcode, accel_sample, column_address, column_data,
                    output ready);
endinterface

interface pov_result_if;
    import pov_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      column_valid;
    logic [PIXEL_W-1:0]        column_pixels;
    logic                      sweep_direction;
    logic signed [ACCEL_W-1:0] filtered_accel;
    logic [RELOAD_W-1:0]       column_reload;

    modport source (output valid, column_valid, column_pixels, sweep_direction,
                           filtered_accel, column_reload,
                    input ready);
    modport sink   (input valid, column_valid, column_pixels, sweep_direction,
                          filtered_accel, column_reload,
                    output ready);
endinterface

interface pov_cfg_if;
    import pov_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/pov_cfg_regs.sv]
// Configuration register file for the sweep controller.
// Depends on pov_pkg and pov_if.

module pov_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pov_cfg_if.sink        i_cfg,
    output pov_pkg::t_cfg  o_cfg
);
    import pov_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swing_threshold      <= THRESH_RESET;
            r_cfg.fixed_rate_enable    <= 1'b0;
            r_cfg.fixed_reload         <= RELOAD_RESET;
            r_cfg.bidirectional_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SWING_THRESHOLD:      r_cfg.swing_threshold <= i_cfg.data[THRESH_W-1:0];
                CFG_FIXED_RATE_ENABLE:    r_cfg.fixed_rate_enable <= i_cfg.data[0];
                CFG_FIXED_RELOAD:         r_cfg.fixed_reload <= i_cfg.data[RELOAD_W-1:0];
                CFG_BIDIRECTIONAL_ENABLE: r_cfg.bidirectional_enable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

[design/pov_column_store.sv]
// Bitmap column memory with per-entry valid bits and a registered read port.
// Depends on pov_pkg.

module pov_column_store #(
    parameter int COLUMNS = pov_pkg::COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pov_pkg::t_store_wr                i_wr,
    input  logic [$clog2(COLUMNS)-1:0]        i_rd_addr,
    output logic [pov_pkg::PIXEL_W-1:0]       o_rd_pixels
);
    import pov_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);

    logic [PIXEL_W-1:0] r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_valid;
    logic [PIXEL_W-1:0] r_rd_data;
    logic               r_rd_hit;
    logic [COL_W-1:0]   wr_addr;
    logic               fwd;

    assign wr_addr = i_wr.addr[COL_W-1:0];
    // write and read of the same entry in one cycle: pass the new data on
    assign fwd     = i_wr.en && (wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        r_rd_data <= fwd ? i_wr.data : r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_hit <= fwd || r_valid[i_rd_addr];
        end
    end

    // never-written entries read as zero
    assign o_rd_pixels = r_rd_hit ? r_rd_data : '0;

endmodule

[design/pov_sweep_core.sv]
// Sweep state and single-item step logic: filter, swing detection, column timer.
// Depends on pov_pkg.

module pov_sweep_core #(
    parameter int COLUMNS = pov_pkg::COLUMNS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  pov_pkg::t_item                i_item,
    input  pov_pkg::t_cfg                 i_cfg,
    input  logic [pov_pkg::PIXEL_W-1:0]   i_rd_pixels,
    output pov_pkg::t_result              o_result,
    output pov_pkg::t_store_wr            o_wr,
    output logic [$clog2(COLUMNS)-1:0]    o_rd_addr
);
    import pov_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W:0]   COLUMNS_EXT = (ADDR_W + 1)'(COLUMNS);

    logic signed [ACCEL_W-1:0] r_filter;
    logic                      r_lock;
    logic                      r_dir;
    logic [COL_W-1:0]          r_col;
    logic [RELOAD_W-1:0]       r_reload;
    logic [RELOAD_W-1:0]       r_timer;
    logic [TICKS_W-1:0]        r_sample_ticks;
    logic [7:0]                r_swing_ticks;

    logic signed [ACCEL_W-1:0] n_filter;
    logic                      n_lock;
    logic                      n_dir;
    logic [COL_W-1:0]          n_col;
    logic [RELOAD_W-1:0]       n_reload;
    logic [RELOAD_W-1:0]       n_timer;
    logic [TICKS_W-1:0]        n_sample_ticks;
    logic [7:0]                n_swing_ticks;

    logic signed [11:0]        sum;
    logic [10:0]               mag;
    logic [23:0]               prod;
    logic [7:0]                quot;
    logic signed [ACCEL_W-1:0] filt;
    logic signed [ACCEL_W-1:0] thr_pos;
    logic signed [ACCEL_W-1:0] thr_neg;
    logic [RELOAD_W-1:0]       cand;
    logic [RELOAD_W-1:0]       timer_inc;
    logic                      col_valid;
    logic [PIXEL_W-1:0]        col_pixels;

    // 9*f + x, then truncating divide by 10 on the magnitude
    always_comb begin
        sum  = ({{4{r_filter[7]}}, r_filter} <<< 3) + {{4{r_filter[7]}}, r_filter}
             + {{4{i_item.accel_sample[7]}}, i_item.accel_sample};
        mag  = sum[11] ? 11'(-sum) : sum[10:0];
        prod = 24'(mag) * 24'(DIV10_MUL);
        quot = prod[DIV10_SHIFT +: 8];
        filt = sum[11] ? 8'(-quot) : quot;
    end

    assign thr_pos   = {1'b0, i_cfg.swing_threshold};
    assign thr_neg   = -thr_pos;
    assign cand      = i_cfg.fixed_rate_enable ? i_cfg.fixed_reload
                     : 8'(9'd257 - {r_swing_ticks, 1'b0});
    assign timer_inc = r_timer + 8'd1;

    always_comb begin
        n_filter       = r_filter;
        n_lock         = r_lock;
        n_dir          = r_dir;
        n_col          = r_col;
        n_reload       = r_reload;
        n_timer        = r_timer;
        n_sample_ticks = r_sample_ticks;
        n_swing_ticks  = r_swing_ticks;
        col_valid      = 1'b0;
        col_pixels     = '0;
        o_wr           = '0;

        case (i_item.opcode)
            OP_SAMPLE: begin
                n_filter       = filt;
                n_sample_ticks = r_sample_ticks + 16'd1;
                // right extreme: restart sweep, maybe adopt new period
                if (filt > thr_pos && filt < FILTER_RAIL && !r_lock) begin
                    n_dir = 1'b0;
                    if (cand > RELOAD_MIN && cand < RELOAD_MAX) begin
                        n_reload = cand;
                    end
                    n_col          = '0;
                    n_sample_ticks = '0;
                    n_lock         = 1'b1;
                end
                // left extreme: remember half-swing length
                if (filt > -FILTER_RAIL && filt < thr_neg && r_lock) begin
                    n_dir         = 1'b1;
                    n_swing_ticks = n_sample_ticks[7:0];
                    n_lock        = 1'b0;
                end
            end
            OP_TICK: begin
                n_timer = timer_inc;
                if (timer_inc == '0) begin
                    col_valid  = 1'b1;
                    col_pixels = i_rd_pixels;
                    if (!r_dir) begin
                        if (r_col < COL_LAST) begin
                            n_col = r_col + COL_W'(1);
                        end
                    end else if (r_col != '0 && i_cfg.bidirectional_enable) begin
                        n_col = r_col - COL_W'(1);
                    end
                    n_timer = r_reload;
                end
            end
            OP_WRITE: begin
                o_wr.en   = i_fire && ({1'b0, i_item.column_address} < COLUMNS_EXT);
                o_wr.addr = i_item.column_address;
                o_wr.data = i_item.column_data;
            end
            default: ;
        endcase
    end

    assign o_rd_addr = i_fire ? n_col : r_col;

    always_comb begin
        o_result.column_valid    = col_valid;
        o_result.column_pixels   = col_pixels;
        o_result.sweep_direction = n_dir;
        o_result.filtered_accel  = n_filter;
        o_result.column_reload   = n_reload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter       <= '0;
            r_lock         <= 1'b0;
            r_dir          <= 1'b0;
            r_col          <= '0;
            r_reload       <= RELOAD_RESET;
            r_timer        <= RELOAD_RESET;
            r_sample_ticks <= '0;
            r_swing_ticks  <= '0;
        end else if (i_fire) begin
            r_filter       <= n_filter;
            r_lock         <= n_lock;
            r_dir          <= n_dir;
            r_col          <= n_col;
            r_reload       <= n_reload;
            r_timer        <= n_timer;
            r_sample_ticks <= n_sample_ticks;
            r_swing_ticks  <= n_swing_ticks;
        end
    end

endmodule

[design/pov_column_sweep_sync.sv]
// Persistence-of-vision sweep controller, top level.
// Path: an input transfer goes through the input reg, then the result reg, to result valid.
// Throughput: one item per cycle while the result sink stays ready; the step logic sits between the two registers.
// Reset: synchronous, active low; clears state, config to defaults, bitmap reads 0.
// Depends on pov_pkg, pov_if, pov_cfg_regs, pov_column_store, pov_sweep_core.

module pov_column_sweep_sync #(
    parameter int COLUMNS = pov_pkg::COLUMNS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pov_item_if.sink      i_item,
    pov_cfg_if.sink       i_cfg,
    pov_result_if.source  o_result
);
    import pov_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);

    // Input register: holds the item whose step runs this cycle
    logic              r_in_valid;
    t_item             r_item;

    // Result register: one result per item, held until the sink takes it
    logic              r_out_valid;
    t_result           r_out;

    logic              advance;
    logic              fire;
    t_cfg              cfg;
    t_result           step_result;
    t_store_wr         store_wr;
    logic [COL_W-1:0]  rd_addr;
    logic [PIXEL_W-1:0] rd_pixels;

    // The result register frees up when empty or when its transfer completes;
    // the staged item then steps and moves into it.
    assign advance      = !r_out_valid || o_result.ready;
    assign fire         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.opcode         <= t_opcode'(i_item.opcode);
            r_item.accel_sample   <= i_item.accel_sample;
            r_item.column_address <= i_item.column_address;
            r_item.column_data    <= i_item.column_data;
        end
        if (fire) begin
            r_out <= step_result;
        end
    end

    pov_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Bitmap memory; the read address is the column index the next item sees,
    // so the pixels are registered and ready when a timer wrap needs them.
    pov_column_store #(
        .COLUMNS (COLUMNS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (store_wr),
        .i_rd_addr   (rd_addr),
        .o_rd_pixels (rd_pixels)
    );

    pov_sweep_core #(
        .COLUMNS (COLUMNS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_cfg       (cfg),
        .i_rd_pixels (rd_pixels),
        .o_result    (step_result),
        .o_wr        (store_wr),
        .o_rd_addr   (rd_addr)
    );

    assign o_result.valid           = r_out_valid;
    assign o_result.column_valid    = r_out.column_valid;
    assign o_result.column_pixels   = r_out.column_pixels;
    assign o_result.sweep_direction = r_out.sweep_direction;
    assign o_result.filtered_accel  = r_out.filtered_accel;
    assign o_result.column_reload   = r_out.column_reload;

endmodule
